FILE: hdl/ffca_pkg.sv
// shared types and codes for the first-fit chunk allocator
// no dependencies; used by every other file of the block
`default_nettype none

package ffca_pkg;

    localparam int KIND_W     = 1;
    localparam int SIZE_IN_W  = 13;
    localparam int OFF_IN_W   = 12;
    localparam int STATUS_W   = 3;
    localparam int S_DATA_W   = 32;
    localparam int S_USER_W   = 2;
    localparam int M_DATA_W   = 16;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_NO_FIT  = 3'd1,
        ST_NULL    = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_DOUBLE  = 3'd4,
        ST_FULL    = 3'd5
    } status_t;

    // control part of the request token that walks the cell row
    typedef struct packed {
        logic    vld;
        logic    kind;
        logic    done;
        logic    full;
        logic    split;
        logic    app_pend;
        status_t status;
    } tok_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/first_fit_chunk_allocator_core.sv
// top level of the first-fit chunk allocator: request entry, cell row, result register
// depends on ffca_pkg and ffca_cell
`default_nettype none

// First-fit allocator over a heap of HEAP_BYTES bytes, tracked as a row of MAX_CHUNKS
// cells, one chunk each. A request word walks the row one cell per clock: the first
// free chunk large enough is taken and any remainder is dropped into the first empty
// cell further down; a free is matched on its offset. One request is handled at a
// time and each walks the whole cell row before its result word is formed; the
// next request is accepted once the result has moved to the output register,
// even if that word is still waiting to be taken. Chunks are never merged.
// Status codes: 0 ok, 1 no fit, 2 null pointer, 3 unknown pointer,
// 4 double free, 5 table full; chunk_offset is 0 unless an allocate succeeds.
module first_fit_chunk_allocator_core #(
    parameter int HEAP_BYTES = 4096,
    parameter int MAX_CHUNKS = 64
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [ffca_pkg::S_DATA_W-1:0]    s_tdata,  // alloc_size, free_offset, zero pad
    input  wire  [ffca_pkg::S_USER_W-1:0]    s_tuser,  // kind, is_null
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [ffca_pkg::M_DATA_W-1:0]    m_tdata   // status, chunk_offset, zero pad
);

    localparam int OFF_W   = (HEAP_BYTES > 2) ? $clog2(HEAP_BYTES) : 1;
    localparam int SIZE_W  = $clog2(HEAP_BYTES + 1);
    localparam int CNT_W   = $clog2(MAX_CHUNKS + 1);
    localparam int CMP_W   = (SIZE_W > ffca_pkg::SIZE_IN_W) ? SIZE_W : ffca_pkg::SIZE_IN_W;
    localparam logic [CMP_W-1:0] HEAP_CMP = CMP_W'(HEAP_BYTES);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_CHUNKS);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    ffca_pkg::tok_ctl_t              ent_ctl_reg, ent_ctl_next;
    logic [SIZE_W-1:0]               ent_size_reg;
    logic [OFF_W-1:0]                ent_off_reg;
    ffca_pkg::status_t               pend_status_reg, pend_status_next;
    logic [ffca_pkg::OFF_IN_W-1:0]   pend_off_reg, pend_off_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    ffca_pkg::status_t               m_status_reg;
    logic [ffca_pkg::OFF_IN_W-1:0]   m_off_reg;

    ffca_pkg::tok_ctl_t              tok_ctl      [MAX_CHUNKS+1];
    logic [SIZE_W-1:0]               tok_size     [MAX_CHUNKS+1];
    logic [OFF_W-1:0]                tok_off      [MAX_CHUNKS+1];
    logic [OFF_W-1:0]                tok_app_off  [MAX_CHUNKS+1];
    logic [SIZE_W-1:0]               tok_app_size [MAX_CHUNKS+1];
    logic [OFF_W-1:0]                tok_res_off  [MAX_CHUNKS+1];

    logic                            s_accept;
    logic                            m_load;
    logic                            req_kind;
    logic                            req_null;
    logic [ffca_pkg::SIZE_IN_W-1:0]  req_size;
    logic [ffca_pkg::OFF_IN_W-1:0]   req_off;
    logic [CMP_W-1:0]                req_size_ext;
    logic [CMP_W-1:0]                req_off_ext;
    ffca_pkg::tok_ctl_t              end_ctl;

    assign req_size     = s_tdata[ffca_pkg::SIZE_IN_W-1:0];
    assign req_off      = s_tdata[ffca_pkg::SIZE_IN_W +: ffca_pkg::OFF_IN_W];
    assign req_kind     = s_tuser[0];
    assign req_null     = s_tuser[1];
    assign req_size_ext = CMP_W'(req_size);
    assign req_off_ext  = CMP_W'(req_off);

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_load   = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);
    assign end_ctl  = tok_ctl[MAX_CHUNKS];

    always_comb begin
        ent_ctl_next      = '0;
        ent_ctl_next.vld  = s_accept;
        ent_ctl_next.kind = req_kind;
        ent_ctl_next.full = (count_reg == CNT_MAX);
        if (req_kind == ffca_pkg::KIND_ALLOC) begin
            if (req_size == '0 || req_size_ext > HEAP_CMP) begin
                ent_ctl_next.done   = 1'b1;
                ent_ctl_next.status = ffca_pkg::ST_NO_FIT;
            end
        end else if (req_null) begin
            ent_ctl_next.done   = 1'b1;
            ent_ctl_next.status = ffca_pkg::ST_NULL;
        end else if (req_off_ext >= HEAP_CMP) begin
            ent_ctl_next.done   = 1'b1;
            ent_ctl_next.status = ffca_pkg::ST_UNKNOWN;
        end
    end

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        pend_status_next = pend_status_reg;
        pend_off_next    = pend_off_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (end_ctl.vld) begin
                    state_next    = S_DONE;
                    pend_off_next = ffca_pkg::OFF_IN_W'(tok_res_off[MAX_CHUNKS]);
                    if (end_ctl.done) begin
                        pend_status_next = end_ctl.status;
                    end else if (end_ctl.kind == ffca_pkg::KIND_ALLOC) begin
                        pend_status_next = ffca_pkg::ST_NO_FIT;
                    end else begin
                        pend_status_next = ffca_pkg::ST_UNKNOWN;
                    end
                    if (end_ctl.split) begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (m_load) begin
                    state_next    = S_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= CNT_W'(1);
            ent_ctl_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ent_ctl_reg  <= ent_ctl_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_size_reg    <= SIZE_W'(req_size);
        ent_off_reg     <= OFF_W'(req_off);
        pend_status_reg <= pend_status_next;
        pend_off_reg    <= pend_off_next;
        if (m_load) begin
            m_status_reg <= pend_status_reg;
            m_off_reg    <= pend_off_reg;
        end
    end

    assign tok_ctl[0]      = ent_ctl_reg;
    assign tok_size[0]     = ent_size_reg;
    assign tok_off[0]      = ent_off_reg;
    assign tok_app_off[0]  = '0;
    assign tok_app_size[0] = '0;
    assign tok_res_off[0]  = '0;

    for (genvar i = 0; i < MAX_CHUNKS; i++) begin : g_cell
        ffca_cell #(
            .HEAP_BYTES (HEAP_BYTES),
            .OFF_W      (OFF_W),
            .SIZE_W     (SIZE_W),
            .INIT_VALID (i == 0)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .in_ctl       (tok_ctl[i]),
            .in_size      (tok_size[i]),
            .in_off       (tok_off[i]),
            .in_app_off   (tok_app_off[i]),
            .in_app_size  (tok_app_size[i]),
            .in_res_off   (tok_res_off[i]),
            .out_ctl      (tok_ctl[i+1]),
            .out_size     (tok_size[i+1]),
            .out_off      (tok_off[i+1]),
            .out_app_off  (tok_app_off[i+1]),
            .out_app_size (tok_app_size[i+1]),
            .out_res_off  (tok_res_off[i+1])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_off_reg, m_status_reg};

endmodule

`default_nettype wire

FILE: hdl/ffca_cell.sv
// one chunk table entry with its slice of the request token path
// depends on ffca_pkg
`default_nettype none

module ffca_cell #(
    parameter int HEAP_BYTES = 4096,
    parameter int OFF_W      = 12,
    parameter int SIZE_W     = 13,
    parameter bit INIT_VALID = 1'b0
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  ffca_pkg::tok_ctl_t    in_ctl,
    input  wire  [SIZE_W-1:0]     in_size,
    input  wire  [OFF_W-1:0]      in_off,
    input  wire  [OFF_W-1:0]      in_app_off,
    input  wire  [SIZE_W-1:0]     in_app_size,
    input  wire  [OFF_W-1:0]      in_res_off,
    output ffca_pkg::tok_ctl_t    out_ctl,
    output logic [SIZE_W-1:0]     out_size,
    output logic [OFF_W-1:0]      out_off,
    output logic [OFF_W-1:0]      out_app_off,
    output logic [SIZE_W-1:0]     out_app_size,
    output logic [OFF_W-1:0]      out_res_off
);

    logic                vld_reg, vld_next;
    logic                free_reg, free_next;
    logic [OFF_W-1:0]    off_reg, off_next;
    logic [SIZE_W-1:0]   size_reg, size_next;

    ffca_pkg::tok_ctl_t  ctl_reg, ctl_next;
    logic [SIZE_W-1:0]   tsize_reg;
    logic [OFF_W-1:0]    toff_reg;
    logic [OFF_W-1:0]    app_off_reg, app_off_next;
    logic [SIZE_W-1:0]   app_size_reg, app_size_next;
    logic [OFF_W-1:0]    res_off_reg, res_off_next;

    logic                fits;
    logic [SIZE_W-1:0]   rest;

    always_comb begin
        vld_next      = vld_reg;
        free_next     = free_reg;
        off_next      = off_reg;
        size_next     = size_reg;
        ctl_next      = in_ctl;
        app_off_next  = in_app_off;
        app_size_next = in_app_size;
        res_off_next  = in_res_off;
        fits          = size_reg >= in_size;
        rest          = size_reg - in_size;
        if (in_ctl.vld) begin
            if (in_ctl.kind == ffca_pkg::KIND_ALLOC) begin
                if (!in_ctl.done && vld_reg && free_reg && fits) begin
                    ctl_next.done = 1'b1;
                    if (rest != '0 && in_ctl.full) begin
                        ctl_next.status = ffca_pkg::ST_FULL;
                    end else begin
                        free_next       = 1'b0;
                        size_next       = in_size;
                        ctl_next.status = ffca_pkg::ST_OK;
                        res_off_next    = off_reg;
                        if (rest != '0) begin
                            ctl_next.split    = 1'b1;
                            ctl_next.app_pend = 1'b1;
                            app_off_next      = off_reg + in_size[OFF_W-1:0];
                            app_size_next     = rest;
                        end
                    end
                end else if (in_ctl.app_pend && !vld_reg) begin
                    // first empty entry takes the remainder
                    vld_next          = 1'b1;
                    free_next         = 1'b1;
                    off_next          = in_app_off;
                    size_next         = in_app_size;
                    ctl_next.app_pend = 1'b0;
                end
            end else if (!in_ctl.done && vld_reg && off_reg == in_off) begin
                ctl_next.done = 1'b1;
                if (free_reg) begin
                    ctl_next.status = ffca_pkg::ST_DOUBLE;
                end else begin
                    free_next       = 1'b1;
                    ctl_next.status = ffca_pkg::ST_OK;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= INIT_VALID;
            free_reg <= 1'b1;
            off_reg  <= '0;
            size_reg <= SIZE_W'(HEAP_BYTES);
            ctl_reg  <= '0;
        end else begin
            vld_reg  <= vld_next;
            free_reg <= free_next;
            off_reg  <= off_next;
            size_reg <= size_next;
            ctl_reg  <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        tsize_reg    <= in_size;
        toff_reg     <= in_off;
        app_off_reg  <= app_off_next;
        app_size_reg <= app_size_next;
        res_off_reg  <= res_off_next;
    end

    assign out_ctl      = ctl_reg;
    assign out_size     = tsize_reg;
    assign out_off      = toff_reg;
    assign out_app_off  = app_off_reg;
    assign out_app_size = app_size_reg;
    assign out_res_off  = res_off_reg;

endmodule

`default_nettype wire

FILE: hdl/ffca_checker.sv
// port-level checks for the first-fit chunk allocator, bound to the top level
// depends on ffca_pkg and first_fit_chunk_allocator_core
`default_nettype none

module ffca_checker (
    input wire                             aclk,
    input wire                             aresetn,
    input wire                             s_tvalid,
    input wire                             s_tready,
    input wire                             m_tvalid,
    input wire                             m_tready,
    input wire [ffca_pkg::M_DATA_W-1:0]    m_tdata
);

    localparam int SW = ffca_pkg::STATUS_W;

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one request at a time
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in flight");

    // no result word is valid just after a request is taken, unless an older one is still stalled
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !(m_tvalid && !m_tready) |=> !m_tvalid)
        else $error("result appeared too early");

    // errors carry a zero offset
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[SW-1:0] != ffca_pkg::ST_OK |->
            m_tdata[SW +: ffca_pkg::OFF_IN_W] == '0)
        else $error("error status with non-zero offset");

endmodule

bind first_fit_chunk_allocator_core ffca_checker u_ffca_checker (.*);

`default_nettype wire
